FILE: rtl/amdfs_pkg.sv
// ----------------------------------------------------------------------------
// amdfs_pkg
// Shared types, codes and helpers for the adjacency-matrix depth-first
// traversal block.
// ----------------------------------------------------------------------------
package amdfs_pkg;

   localparam int MASK_W   = 32;
   localparam int VERTEX_W = 5;
   localparam int COUNT_W  = 6;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Function codes of an input item.
   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_TRAVERSE = 1'b1;

   typedef struct packed {
      logic                func;
      logic [VERTEX_W-1:0] row_index;
      logic [MASK_W-1:0]   row_mask;
   } cmd_type;

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_RUN,
      WALK_FLUSH
   } walk_state_type;

   // Index of the lowest set bit; only used on a nonzero mask.
   function automatic logic [VERTEX_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
      logic [VERTEX_W-1:0] r;
      r = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = VERTEX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/amdfs_cmd_queue.sv
// ----------------------------------------------------------------------------
// amdfs_cmd_queue
// Small FIFO that decouples item intake from the traversal engine.
// ----------------------------------------------------------------------------
module amdfs_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_stall,
   input  amdfs_pkg::cmd_type  push_cmd,
   output logic                pop_valid,
   input  logic                pop,
   output amdfs_pkg::cmd_type  pop_cmd
);

   amdfs_pkg::cmd_type               entry_ff [amdfs_pkg::QUEUE_DEPTH];
   logic [amdfs_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [amdfs_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [amdfs_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign push_stall = (count_ff == amdfs_pkg::QCNT_W'(amdfs_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == amdfs_pkg::QPTR_W'(amdfs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == amdfs_pkg::QPTR_W'(amdfs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/amdfs_walker.sv
// ----------------------------------------------------------------------------
// amdfs_walker
// Back end: holds the adjacency rows, runs the stack-based depth-first walk
// and drives the result register.
// ----------------------------------------------------------------------------
module amdfs_walker #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  amdfs_pkg::cmd_type                cmd,
   output logic                              cmd_pop,
   input  logic [amdfs_pkg::MASK_W-1:0]      in_use,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [amdfs_pkg::VERTEX_W-1:0]    rsp_vertex_index,
   output logic                              rsp_last_of_run
);

   localparam int ROWS = (MAX_VERTICES < amdfs_pkg::MASK_W) ? MAX_VERTICES
                                                             : amdfs_pkg::MASK_W;
   localparam int IW   = $clog2(ROWS);
   localparam int DW   = $clog2(ROWS + 1);

   amdfs_pkg::walk_state_type         state_ff, state_in;
   logic [amdfs_pkg::MASK_W-1:0]      rows_ff  [ROWS];
   logic [amdfs_pkg::VERTEX_W-1:0]    stack_ff [ROWS];
   logic [DW-1:0]                     depth_ff, depth_in;
   logic [amdfs_pkg::MASK_W-1:0]      visited_ff, visited_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [amdfs_pkg::VERTEX_W-1:0]    pend_vertex_ff, pend_vertex_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [amdfs_pkg::VERTEX_W-1:0]    rsp_vertex_ff, rsp_vertex_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              row_we;
   logic                              stack_we;
   logic                              out_free;
   logic [DW-1:0]                     depth_m1;
   logic [amdfs_pkg::VERTEX_W-1:0]    top_vertex;
   logic [amdfs_pkg::MASK_W-1:0]      fresh;
   logic [amdfs_pkg::MASK_W-1:0]      cand;
   logic                              found;
   logic [amdfs_pkg::VERTEX_W-1:0]    next_vertex;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_vertex_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign depth_m1    = depth_ff - 1'b1;
   assign top_vertex  = stack_ff[depth_m1[IW-1:0]];
   assign fresh       = in_use & ~visited_ff;
   // Empty stack: open a new component at the lowest unvisited vertex.
   assign cand        = (depth_ff == '0) ? fresh : (rows_ff[top_vertex[IW-1:0]] & fresh);
   assign found       = |cand;
   assign next_vertex = amdfs_pkg::lowest_bit(cand);

   always_comb begin
      state_in       = state_ff;
      depth_in       = depth_ff;
      visited_in     = visited_ff;
      pend_valid_in  = pend_valid_ff;
      pend_vertex_in = pend_vertex_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_vertex_in  = rsp_vertex_ff;
      rsp_last_in    = rsp_last_ff;
      row_we         = 1'b0;
      stack_we       = 1'b0;
      cmd_pop        = 1'b0;

      case (state_ff)
         amdfs_pkg::WALK_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid) begin
               if (cmd.func == amdfs_pkg::FUNC_LOAD) begin
                  row_we = ({1'b0, cmd.row_index} < (amdfs_pkg::VERTEX_W + 1)'(ROWS));
               end else begin
                  visited_in    = '0;
                  depth_in      = '0;
                  pend_valid_in = 1'b0;
                  state_in      = amdfs_pkg::WALK_RUN;
               end
            end
         end
         amdfs_pkg::WALK_RUN: begin
            if (found) begin
               // Hold the discovery until the previous vertex can be shipped.
               if (!pend_valid_ff || out_free) begin
                  visited_in = visited_ff | (amdfs_pkg::MASK_W'(1) << next_vertex);
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_vertex_in = pend_vertex_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_vertex_in = next_vertex;
                  if (depth_ff < DW'(ROWS)) begin
                     stack_we = 1'b1;
                     depth_in = depth_ff + 1'b1;
                  end
               end
            end else if (depth_ff != '0) begin
               depth_in = depth_m1;
            end else begin
               state_in = amdfs_pkg::WALK_FLUSH;
            end
         end
         amdfs_pkg::WALK_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = amdfs_pkg::WALK_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = pend_vertex_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = amdfs_pkg::WALK_IDLE;
            end
         end
         default: begin
            state_in = amdfs_pkg::WALK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= amdfs_pkg::WALK_IDLE;
         depth_ff      <= '0;
         visited_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         visited_ff    <= visited_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_vertex_ff <= pend_vertex_in;
      rsp_vertex_ff  <= rsp_vertex_in;
      rsp_last_ff    <= rsp_last_in;
      if (stack_we) begin
         stack_ff[depth_ff[IW-1:0]] <= next_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++) begin
            rows_ff[i] <= '0;
         end
      end else if (row_we) begin
         rows_ff[cmd.row_index[IW-1:0]] <= cmd.row_mask;
      end
   end

endmodule

FILE: rtl/adjacency_matrix_dfs_order_top.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_order_top
// Load item: one row loads per cycle back to back while no walk is running.
// Traverse item: the walk starts once the item is taken; each step either finds
//   a vertex or backtracks one level.
// A vertex leaves on the edge that finds the next one; the last one leaves from
//   the flush state once the stack runs dry. A stalled response holds the walk.
// Reset clears the rows, the queue and the walk state, and sets the count to 32.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_order_top #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration
   input  logic                               csr_write_enable,
   input  logic [amdfs_pkg::COUNT_W-1:0]      csr_vertex_count,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [amdfs_pkg::VERTEX_W-1:0]     req_row_index,
   input  logic [amdfs_pkg::MASK_W-1:0]       req_row_mask,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [amdfs_pkg::VERTEX_W-1:0]     rsp_vertex_index,
   output logic                               rsp_last_of_run
);

   // Count actually usable: limited by the build size and by the 32-bit masks.
   localparam int LIMIT = (MAX_VERTICES < amdfs_pkg::MASK_W) ? MAX_VERTICES
                                                              : amdfs_pkg::MASK_W;

   logic [amdfs_pkg::COUNT_W-1:0]   vertex_count_ff, vertex_count_in;
   logic [amdfs_pkg::COUNT_W-1:0]   active_count;
   logic [amdfs_pkg::MASK_W-1:0]    in_use;
   amdfs_pkg::cmd_type              req_cmd;
   amdfs_pkg::cmd_type              head_cmd;
   logic                            head_valid;
   logic                            head_pop;

   // Vertex count register; the user writes it only while the block is idle; not enforced.
   assign vertex_count_in = csr_write_enable ? csr_vertex_count : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= amdfs_pkg::COUNT_W'(32);
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // Clamp the count and expand it into the in-use vertex mask.
   assign active_count = (vertex_count_ff > amdfs_pkg::COUNT_W'(LIMIT)) ?
                         amdfs_pkg::COUNT_W'(LIMIT) : vertex_count_ff;

   always_comb begin
      for (int i = 0; i < amdfs_pkg::MASK_W; i++) begin
         in_use[i] = (amdfs_pkg::COUNT_W'(i) < active_count);
      end
   end

   // Front: pack the item and queue it, so intake runs while a walk is busy.
   always_comb begin
      req_cmd.func      = req_func;
      req_cmd.row_index = req_row_index;
      req_cmd.row_mask  = req_row_mask;
   end

   amdfs_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_cmd   (req_cmd),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .pop_cmd    (head_cmd)
   );

   // Back: row loads and the depth-first walk, in queue order.
   amdfs_walker #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_walker (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (head_valid),
      .cmd              (head_cmd),
      .cmd_pop          (head_pop),
      .in_use           (in_use),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb - regression bench for adjacency_matrix_dfs_order_top
// Loads adjacency rows and traverse commands through the request channel. A
// local predictor keeps a copy of the row matrix and the vertex count and
// works out the depth-first visit order of every traverse. Each response
// item is checked against the oldest predicted vertex. The run covers
// directed corner graphs, vertex count limits, a long response hold-off and
// random graphs under several idling mixes.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_VERTICES   = 32;
   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 12;
   // Loads leave no response behind, so let the engine and its two-entry
   // queue settle for a while before touching the register.
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int LIMIT_CYCLES   = 1000000;

   // One predicted response item.
   typedef struct packed {
      logic [amdfs_pkg::VERTEX_W-1:0] vertex_index;
      logic                           last_of_run;
   } visit_type;

   // ------------------------------------------------------------------------
   // Block ports; every input starts at a known value.
   // ------------------------------------------------------------------------
   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [amdfs_pkg::COUNT_W-1:0]  csr_vertex_count = '0;
   logic                           req_valid        = 1'b0;
   logic                           req_stall;
   logic                           req_func         = amdfs_pkg::FUNC_LOAD;
   logic [amdfs_pkg::VERTEX_W-1:0] req_row_index    = '0;
   logic [amdfs_pkg::MASK_W-1:0]   req_row_mask     = '0;
   logic                           rsp_valid;
   logic                           rsp_stall        = 1'b0;
   logic [amdfs_pkg::VERTEX_W-1:0] rsp_vertex_index;
   logic                           rsp_last_of_run;

   adjacency_matrix_dfs_order_top #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_vertex_count(csr_vertex_count),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_row_index   (req_row_index),
      .req_row_mask    (req_row_mask),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vertex_index(rsp_vertex_index),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: a private copy of the row matrix and the count.
   // ------------------------------------------------------------------------
   logic [amdfs_pkg::MASK_W-1:0]  row_matrix [MAX_VERTICES];
   logic [amdfs_pkg::COUNT_W-1:0] vertex_count_copy;
   visit_type                     visit_order_q[$];
   visit_type                     expected_visit;

   int error_count    = 0;
   int leftover_count = 0;
   int items_sent     = 0;

   // Idling knobs, in percent per cycle.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // Hold-off handshake: the test bumps the request count, the stall
   // process notices and counts the stretch down on its own.
   int holdoff_requests = 0;
   int holdoff_served   = 0;
   int holdoff_left     = 0;

   // Index of the lowest set bit, zero for an empty mask.
   function automatic int first_set(input logic [amdfs_pkg::MASK_W-1:0] m);
      int idx;
      idx = -1;
      for (int i = 0; i < amdfs_pkg::MASK_W; i++) begin
         if (idx < 0 && m[i]) begin
            idx = i;
         end
      end
      return (idx < 0) ? 0 : idx;
   endfunction

   // Vertices in use: the register clipped to the matrix size and mask width.
   function automatic int active_vertices();
      int n;
      n = int'(vertex_count_copy);
      if (n > MAX_VERTICES) begin
         n = MAX_VERTICES;
      end
      if (n > amdfs_pkg::MASK_W) begin
         n = amdfs_pkg::MASK_W;
      end
      return n;
   endfunction

   // Walk the graph depth first and queue every vertex in visit order.
   task automatic predict_visit_order();
      logic [amdfs_pkg::MASK_W-1:0] in_use;
      logic [amdfs_pkg::MASK_W-1:0] visited;
      logic [amdfs_pkg::MASK_W-1:0] cand;
      int                           path [MAX_VERTICES];
      int                           n;
      int                           depth;
      int                           start;
      int                           next_v;
      visit_type                    walk_q[$];
      visit_type                    v;
      n       = active_vertices();
      in_use  = (n >= amdfs_pkg::MASK_W) ? '1 :
                ((amdfs_pkg::MASK_W'(1) << n) - amdfs_pkg::MASK_W'(1));
      visited = '0;
      v.last_of_run = 1'b0;
      while ((in_use & ~visited) != '0) begin
         // Open a new component at the lowest vertex not yet seen.
         start = first_set(in_use & ~visited);
         visited[start] = 1'b1;
         v.vertex_index = amdfs_pkg::VERTEX_W'(start);
         walk_q.push_back(v);
         path[0] = start;
         depth   = 1;
         while (depth > 0) begin
            cand = row_matrix[path[depth-1]] & in_use & ~visited;
            if (cand != '0) begin
               next_v = first_set(cand);
               visited[next_v] = 1'b1;
               v.vertex_index  = amdfs_pkg::VERTEX_W'(next_v);
               walk_q.push_back(v);
               if (depth < MAX_VERTICES) begin
                  path[depth] = next_v;
                  depth++;
               end
            end else begin
               depth--;
            end
         end
      end
      if (walk_q.size() > 0) begin
         walk_q[walk_q.size()-1].last_of_run = 1'b1;
      end
      foreach (walk_q[i]) begin
         visit_order_q.push_back(walk_q[i]);
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side: offer one item, hold it until it is taken, then update
   // the predictor. Valid stays high on return so back-to-back items need
   // no second assignment in the same step.
   // ------------------------------------------------------------------------
   task automatic send_item(input logic func,
                            input logic [amdfs_pkg::VERTEX_W-1:0] row,
                            input logic [amdfs_pkg::MASK_W-1:0] mask);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_row_index <= row;
      req_row_mask  <= mask;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (func == amdfs_pkg::FUNC_LOAD) begin
         row_matrix[row] = mask;
      end else begin
         predict_visit_order();
      end
      items_sent++;
   endtask

   // Drop valid, wait for every predicted item, then let the engine settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (visit_order_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the vertex count only while the block is idle.
   task automatic write_vertex_count(input logic [amdfs_pkg::COUNT_W-1:0] count);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_vertex_count <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      vertex_count_copy = count;
   endtask

   // Mix of empty, dense and sparse rows; sparse ones give deeper walks.
   function automatic logic [amdfs_pkg::MASK_W-1:0] random_row_mask();
      case ($urandom_range(4))
         0: return '0;
         1: return $urandom();
         2: return $urandom() & $urandom();
         3: return $urandom() & $urandom() & $urandom();
         default: return (amdfs_pkg::MASK_W'(1) << $urandom_range(amdfs_pkg::MASK_W-1)) |
                         (amdfs_pkg::MASK_W'(1) << $urandom_range(amdfs_pkg::MASK_W-1));
      endcase
   endfunction

   // Mostly legal counts, now and then one of the out-of-range ones.
   function automatic logic [amdfs_pkg::COUNT_W-1:0] random_vertex_count();
      case ($urandom_range(9))
         0: return amdfs_pkg::COUNT_W'(0);
         1: return amdfs_pkg::COUNT_W'($urandom_range(33, 63));
         2: return amdfs_pkg::COUNT_W'(32);
         3, 4: return amdfs_pkg::COUNT_W'($urandom_range(1, 6));
         default: return amdfs_pkg::COUNT_W'($urandom_range(1, 32));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // After reset every row is empty: each vertex is its own component.
   task automatic test_reset_state();
      send_item(amdfs_pkg::FUNC_TRAVERSE, '0, '0);
   endtask

   // Self loops, back edges, a cycle and the extreme row masks.
   task automatic test_directed_graphs();
      send_item(amdfs_pkg::FUNC_LOAD, 5'd0, 32'h8000_0005);
      send_item(amdfs_pkg::FUNC_LOAD, 5'd2, 32'h0000_0010);
      send_item(amdfs_pkg::FUNC_LOAD, 5'd4, 32'h0000_0001);
      send_item(amdfs_pkg::FUNC_LOAD, 5'd31, 32'hFFFF_FFFF);
      send_item(amdfs_pkg::FUNC_LOAD, 5'd7, 32'h0000_0000);
      send_item(amdfs_pkg::FUNC_LOAD, 5'd1, 32'h0000_0000);
      send_item(amdfs_pkg::FUNC_TRAVERSE, 5'd31, 32'hFFFF_FFFF);
      send_item(amdfs_pkg::FUNC_LOAD, 5'd3, 32'h0000_0200);
      send_item(amdfs_pkg::FUNC_LOAD, 5'd9, 32'h0000_0008);
      send_item(amdfs_pkg::FUNC_TRAVERSE, 5'd0, 32'h0000_0000);
   endtask

   // Single vertex, zero vertices, counts above the matrix size, and edges
   // that point past the vertices in use.
   task automatic test_count_limits();
      write_vertex_count(amdfs_pkg::COUNT_W'(1));
      send_item(amdfs_pkg::FUNC_TRAVERSE, '0, '0);
      write_vertex_count(amdfs_pkg::COUNT_W'(0));
      send_item(amdfs_pkg::FUNC_TRAVERSE, '0, '0);
      write_vertex_count(amdfs_pkg::COUNT_W'(63));
      send_item(amdfs_pkg::FUNC_TRAVERSE, '0, '0);
      write_vertex_count(amdfs_pkg::COUNT_W'(33));
      send_item(amdfs_pkg::FUNC_TRAVERSE, '0, '0);
      write_vertex_count(amdfs_pkg::COUNT_W'(4));
      send_item(amdfs_pkg::FUNC_LOAD, 5'd1, 32'hFFFF_FFF0);
      send_item(amdfs_pkg::FUNC_LOAD, 5'd2, 32'hF000_0002);
      send_item(amdfs_pkg::FUNC_TRAVERSE, '0, '0);
      write_vertex_count(amdfs_pkg::COUNT_W'(32));
   endtask

   // Hold the response side off for a long stretch while a chain through
   // all vertices is walked again and again: the stack goes full depth and
   // the request side has to stall.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_vertex_count(amdfs_pkg::COUNT_W'(32));
      for (int i = 0; i < MAX_VERTICES - 1; i++) begin
         send_item(amdfs_pkg::FUNC_LOAD, amdfs_pkg::VERTEX_W'(i),
                   amdfs_pkg::MASK_W'(1) << (i + 1));
      end
      send_item(amdfs_pkg::FUNC_LOAD, amdfs_pkg::VERTEX_W'(MAX_VERTICES - 1),
                32'h0000_0001);
      holdoff_requests++;
      repeat (8) begin
         send_item(amdfs_pkg::FUNC_TRAVERSE, amdfs_pkg::VERTEX_W'($urandom()), $urandom());
      end
      wait_idle();
   endtask

   // Random graphs: mostly a few rows of the vertices in use followed by a
   // traverse, with stray loads and bare traverses mixed in as noise.
   task automatic test_random_graphs(input int idle_pct, input int stall_pct,
                                     input int item_goal);
      int goal;
      int n;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      write_vertex_count(random_vertex_count());
      goal = items_sent + item_goal;
      while (items_sent < goal) begin
         if ($urandom_range(9) == 0) begin
            write_vertex_count(random_vertex_count());
         end
         if ($urandom_range(99) < 85) begin
            n = active_vertices();
            repeat ($urandom_range(1, 6)) begin
               send_item(amdfs_pkg::FUNC_LOAD,
                         (n > 0) ? amdfs_pkg::VERTEX_W'($urandom_range(n - 1)) :
                                   amdfs_pkg::VERTEX_W'($urandom()),
                         random_row_mask());
            end
            send_item(amdfs_pkg::FUNC_TRAVERSE, amdfs_pkg::VERTEX_W'($urandom()), $urandom());
         end else if ($urandom_range(1) == 0) begin
            send_item(amdfs_pkg::FUNC_LOAD, amdfs_pkg::VERTEX_W'($urandom()), $urandom());
         end else begin
            send_item(amdfs_pkg::FUNC_TRAVERSE, amdfs_pkg::VERTEX_W'($urandom()), $urandom());
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: stall at random, or hold off for a counted stretch.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (holdoff_requests != holdoff_served) begin
         holdoff_served = holdoff_requests;
         holdoff_left   = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Check each accepted response item against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (visit_order_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected vertex: expected none, actual vertex %0d last %0b",
                     $time, rsp_vertex_index, rsp_last_of_run);
         end else begin
            expected_visit = visit_order_q.pop_front();
            if (rsp_vertex_index !== expected_visit.vertex_index) begin
               error_count++;
               $display("%0t: vertex_index mismatch: expected %0d, actual %0d",
                        $time, expected_visit.vertex_index, rsp_vertex_index);
            end
            if (rsp_last_of_run !== expected_visit.last_of_run) begin
               error_count++;
               $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                        $time, expected_visit.last_of_run, rsp_last_of_run);
            end
         end
      end
   end

   // Watchdog: end the run if it goes far past any sane length.
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("adjacency_matrix_dfs_order_top regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      foreach (row_matrix[i]) begin
         row_matrix[i] = '0;
      end
      vertex_count_copy = amdfs_pkg::COUNT_W'(32);

      // Hold reset, then release it on a clock edge.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_graphs();
      test_count_limits();
      test_backpressure();
      test_random_graphs(0, 0, 50);
      test_random_graphs(50, 0, 50);
      test_random_graphs(0, 50, 50);
      test_random_graphs(35, 35, 50);

      // Drain, then count whatever was predicted but never came out.
      wait_idle();
      leftover_count = visit_order_q.size();
      if (leftover_count != 0) begin
         $display("%0t: %0d predicted vertices never arrived, next expected vertex %0d",
                  $time, leftover_count, visit_order_q[0].vertex_index);
      end

      if (error_count == 0 && leftover_count == 0) begin
         $display("adjacency_matrix_dfs_order_top regression: pass");
      end else begin
         $display("adjacency_matrix_dfs_order_top regression: fail");
      end
      $finish;
   end

endmodule
